/* hdl/hmm_mlsp_pkg.sv */
`default_nettype none
package hmm_mlsp_pkg;

   localparam int MAX_STATES  = 8;
   localparam int MAX_SYMBOLS = 16;
   localparam int MAX_OBS     = 64;
   localparam int PROB_BITS   = 16;

   localparam int SB  = $clog2(MAX_STATES);
   localparam int YB  = $clog2(MAX_SYMBOLS);
   localparam int OB  = $clog2(MAX_OBS);

   localparam logic [1:0] OP_LOAD_TRANS = 2'd0;
   localparam logic [1:0] OP_LOAD_EMIS  = 2'd1;
   localparam logic [1:0] OP_LOAD_INIT  = 2'd2;
   localparam logic [1:0] OP_OBSERVE    = 2'd3;

   localparam logic CSR_NUM_STATES  = 1'b0;
   localparam logic CSR_NUM_SYMBOLS = 1'b1;

   typedef struct packed {
      logic          load;
      logic          issue;
      logic [SB-1:0] p;
      logic [SB-1:0] j;
      logic          lastp;
      logic          init_mode;
      logic [YB-1:0] sym;
      logic          sym_ok;
      logic [OB-1:0] step_idx;
      logic          commit;
      logic [SB-1:0] nlast;
      logic          am_clear;
      logic          am_step;
      logic          bp_rd;
      logic          cur_from_bp;
      logic          path_we;
      logic          path_src_bp;
      logic [OB-1:0] path_idx;
      logic          path_rd;
      logic          rsp_load;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

endpackage
`default_nettype wire

/* hdl/hmm_mlsp_dp.sv */
`default_nettype none
module hmm_mlsp_dp
   import hmm_mlsp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cmd_type        cmd,
   input  wire logic [1:0]     req_op,
   input  wire logic [2:0]     req_row,
   input  wire logic [3:0]     req_col,
   input  wire logic [15:0]    req_prob,
   output status_type          status,
   output logic [2:0]          rsp_state_index
);

   typedef struct packed {
      logic          vld;
      logic [SB-1:0] p;
      logic [SB-1:0] j;
      logic          lastp;
   } tag_type;

   logic [PROB_BITS-1:0] trans_mem [MAX_STATES*MAX_STATES];
   logic [PROB_BITS-1:0] emis_mem  [MAX_STATES*MAX_SYMBOLS];
   logic [SB-1:0]        bp_mem    [MAX_OBS*MAX_STATES];
   logic [SB-1:0]        path_mem  [MAX_OBS];
   logic [PROB_BITS-1:0] init_ff   [MAX_STATES];
   logic [PROB_BITS-1:0] score_ff  [MAX_STATES];
   logic [PROB_BITS-1:0] next_ff   [MAX_STATES];

   tag_type              tag0_ff, tag1_ff, tag2_ff;
   logic [PROB_BITS-1:0] trans_rd_ff, emis_rd_ff, a_ff, prod_ff, e_ff, val_ff;
   logic [PROB_BITS-1:0] best_ff, cand_best, am_best_ff, score_rd;
   logic [SB-1:0]        arg_ff, cand_arg, cur_ff, bp_rd_ff, path_rd_ff, state_ff;
   logic [2*PROB_BITS-1:0] mul1, mul2;

   assign score_rd = score_ff[cmd.p];
   assign mul1 = a_ff * trans_rd_ff;
   assign mul2 = prod_ff * e_ff;

   // table loads
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         unique case (req_op)
            OP_LOAD_TRANS: if ({1'b0, req_col} < 5'(MAX_STATES))
               trans_mem[{req_row, req_col[SB-1:0]}] <= req_prob;
            OP_LOAD_EMIS:  emis_mem[{req_row, req_col}] <= req_prob;
            OP_LOAD_INIT:  init_ff[req_row] <= req_prob;
            default: ;
         endcase
      end
   end

   // product pipeline
   always_ff @(posedge clock) begin
      trans_rd_ff <= trans_mem[{cmd.p, cmd.j}];
      emis_rd_ff  <= emis_mem[{cmd.j, cmd.sym}];
      a_ff        <= cmd.init_mode ? init_ff[cmd.j] : score_rd;
      prod_ff     <= cmd.init_mode ? a_ff : mul1[2*PROB_BITS-1:PROB_BITS];
      e_ff        <= cmd.sym_ok ? emis_rd_ff : '0;
      val_ff      <= mul2[2*PROB_BITS-1:PROB_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag0_ff <= '{vld: cmd.issue, p: cmd.p, j: cmd.j, lastp: cmd.lastp};
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
      end
   end

   assign status.busy = tag0_ff.vld | tag1_ff.vld | tag2_ff.vld;

   // running max, lowest index wins a tie
   always_comb begin
      if (tag2_ff.p == '0) begin
         cand_best = val_ff;
         cand_arg  = '0;
      end else if (val_ff > best_ff) begin
         cand_best = val_ff;
         cand_arg  = tag2_ff.p;
      end else begin
         cand_best = best_ff;
         cand_arg  = arg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.vld) begin
         best_ff <= cand_best;
         arg_ff  <= cand_arg;
         if (tag2_ff.lastp) begin
            next_ff[tag2_ff.j] <= cand_best;
            bp_mem[{cmd.step_idx, tag2_ff.j}] <= cand_arg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_STATES; k++) score_ff[k] <= '0;
      end else if (cmd.commit) begin
         for (int k = 0; k < MAX_STATES; k++)
            if (SB'(k) <= cmd.nlast) score_ff[k] <= next_ff[k];
      end
   end

   // final argmax and backtrack
   always_ff @(posedge clock) begin
      if (cmd.am_clear) begin
         am_best_ff <= '0;
         cur_ff     <= '0;
      end else if (cmd.am_step && score_rd > am_best_ff) begin
         am_best_ff <= score_rd;
         cur_ff     <= cmd.p;
      end else if (cmd.cur_from_bp) begin
         cur_ff <= bp_rd_ff;
      end
      if (cmd.bp_rd) bp_rd_ff <= bp_mem[{cmd.path_idx, cur_ff}];
      if (cmd.path_we) path_mem[cmd.path_idx] <= cmd.path_src_bp ? bp_rd_ff : cur_ff;
      if (cmd.path_rd) path_rd_ff <= path_mem[cmd.path_idx];
      if (cmd.rsp_load) state_ff <= path_rd_ff;
   end

   assign rsp_state_index = state_ff;

endmodule
`default_nettype wire

/* hdl/hmm_mlsp_ctrl.sv */
`default_nettype none
module hmm_mlsp_ctrl
   import hmm_mlsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_symbol,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_last_of_path,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_wdata,
   input  wire status_type  status,
   output cmd_type          cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_RUN    = 4'd1;
   localparam logic [3:0] S_DRAIN  = 4'd2;
   localparam logic [3:0] S_COMMIT = 4'd3;
   localparam logic [3:0] S_AMAX   = 4'd4;
   localparam logic [3:0] S_AWR    = 4'd5;
   localparam logic [3:0] S_BRD    = 4'd6;
   localparam logic [3:0] S_BWR    = 4'd7;
   localparam logic [3:0] S_ERD    = 4'd8;
   localparam logic [3:0] S_ELD    = 4'd9;
   localparam logic [3:0] S_EHOLD  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [3:0]    num_states_ff;
   logic [4:0]    num_symbols_ff;
   logic [OB:0]   step_ff, step_in;
   logic [SB-1:0] p_ff, p_in, j_ff, j_in, nlast;
   logic [OB-1:0] t_ff, t_in, len_m1;
   logic [YB-1:0] sym_ff;
   logic          last_ff, init_ff, valid_ff, valid_in, rlast_ff, rlast_in;
   logic [4:0]    nsym;
   logic          accept, lastp;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = valid_ff;
   assign rsp_last_of_path = rlast_ff;

   always_comb begin
      if (num_states_ff == '0) nlast = '0;
      else if (num_states_ff > 4'(MAX_STATES)) nlast = SB'(MAX_STATES - 1);
      else nlast = SB'(num_states_ff - 4'd1);
      if (num_symbols_ff == '0) nsym = 5'd1;
      else if (num_symbols_ff > 5'(MAX_SYMBOLS)) nsym = 5'(MAX_SYMBOLS);
      else nsym = num_symbols_ff;
   end

   assign lastp  = init_ff || (p_ff == nlast);
   assign len_m1 = OB'(step_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= 4'(MAX_STATES);
         num_symbols_ff <= 5'(MAX_SYMBOLS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_STATES:  num_states_ff  <= csr_wdata[3:0];
            CSR_NUM_SYMBOLS: num_symbols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
         init_ff <= (step_ff == '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      p_in     = p_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      valid_in = valid_ff;
      rlast_in = rlast_ff;
      unique case (state_ff)
         S_IDLE: if (accept && req_op == OP_OBSERVE) begin
            p_in = '0;
            j_in = '0;
            if (step_ff < (OB+1)'(MAX_OBS)) state_in = S_RUN;
            else if (req_last) state_in = S_AMAX;
         end
         S_RUN: begin
            if (lastp) begin
               p_in = '0;
               if (j_ff == nlast) state_in = S_DRAIN;
               else j_in = j_ff + 1'b1;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         S_DRAIN: if (!status.busy) state_in = S_COMMIT;
         S_COMMIT: begin
            step_in  = step_ff + 1'b1;
            state_in = last_ff ? S_AMAX : S_IDLE;
         end
         S_AMAX: begin
            if (p_ff == nlast) state_in = S_AWR;
            else p_in = p_ff + 1'b1;
         end
         S_AWR: begin
            t_in     = len_m1;
            state_in = (len_m1 == '0) ? S_ERD : S_BRD;
         end
         S_BRD: state_in = S_BWR;
         S_BWR: begin
            t_in     = t_ff - 1'b1;
            state_in = (t_ff == OB'(1)) ? S_ERD : S_BRD;
         end
         S_ERD: state_in = S_ELD;
         S_ELD: begin
            valid_in = 1'b1;
            rlast_in = (t_ff == len_m1);
            state_in = S_EHOLD;
         end
         S_EHOLD: if (!rsp_stall) begin
            valid_in = 1'b0;
            if (t_ff == len_m1) begin
               step_in  = '0;
               state_in = S_IDLE;
            end else begin
               t_in     = t_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         p_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
         valid_ff <= 1'b0;
         rlast_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         p_ff     <= p_in;
         j_ff     <= j_in;
         t_ff     <= t_in;
         valid_ff <= valid_in;
         rlast_ff <= rlast_in;
      end
   end

   always_comb begin
      cmd             = '0;
      cmd.load        = accept && req_op != OP_OBSERVE;
      cmd.issue       = (state_ff == S_RUN);
      cmd.p           = p_ff;
      cmd.j           = j_ff;
      cmd.lastp       = lastp;
      cmd.init_mode   = init_ff;
      cmd.sym         = sym_ff;
      cmd.sym_ok      = ({1'b0, sym_ff} < nsym);
      cmd.step_idx    = step_ff[OB-1:0];
      cmd.commit      = (state_ff == S_COMMIT);
      cmd.nlast       = nlast;
      cmd.am_clear    = (state_ff == S_IDLE) || (state_ff == S_COMMIT);
      cmd.am_step     = (state_ff == S_AMAX);
      cmd.bp_rd       = (state_ff == S_BRD);
      cmd.cur_from_bp = (state_ff == S_BWR);
      cmd.path_we     = (state_ff == S_AWR) || (state_ff == S_BWR);
      cmd.path_src_bp = (state_ff == S_BWR);
      cmd.path_idx    = (state_ff == S_AWR) ? len_m1 :
                        (state_ff == S_BWR) ? OB'(t_ff - 1'b1) : t_ff;
      cmd.path_rd     = (state_ff == S_ERD);
      cmd.rsp_load    = (state_ff == S_ELD);
   end

endmodule
`default_nettype wire

/* hdl/hmm_most_likely_state_path.sv */
`default_nettype none
// a load writes its table entry on acceptance; an observation runs the single
// multiply-compare pipeline over all state pairs (over single states for the first of a sequence)
// a last observation adds a final argmax over the states and a backtrack through the
// backpointer memory, then delivers the path one entry at a time, held by any output stall
// one request at a time: req_stall is high while an observation or its path is in progress
// synchronous active-high reset clears control and scores, presets CSRs; tables not reset
module hmm_most_likely_state_path
   import hmm_mlsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [2:0]  req_row,
   input  wire logic [3:0]  req_col,
   input  wire logic [15:0] req_prob,
   input  wire logic [3:0]  req_symbol,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_state_index,
   output logic             rsp_last_of_path,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [4:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   hmm_mlsp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_op, .req_symbol, .req_last,
      .rsp_valid, .rsp_stall, .rsp_last_of_path, .csr_we, .csr_index, .csr_wdata,
      .status, .cmd
   );

   hmm_mlsp_dp u_dp (
      .clock, .reset, .cmd, .req_op, .req_row, .req_col, .req_prob,
      .status, .rsp_state_index
   );

`ifndef ASSERT_OFF
   a_no_request_during_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while path output pending");
   a_one_cycle_handover: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid) else $error("result repeated");
   a_no_output_while_computing: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !rsp_valid) else $error("result during recurrence");
`endif

endmodule
`default_nettype wire
